### rtl/adsr_pkg.sv
package adsr_pkg;

   // Widths of the configuration port, the action code and the level output.
   localparam int REG_W   = 24;
   localparam int ENV_W   = 24;
   localparam int INDEX_W = 3;
   localparam int ACT_W   = 2;

   // Action codes carried by an input beat.
   localparam logic [ACT_W-1:0] ACT_SAMPLE   = 2'd0;
   localparam logic [ACT_W-1:0] ACT_NOTE_ON  = 2'd1;
   localparam logic [ACT_W-1:0] ACT_NOTE_OFF = 2'd2;

   // Register indexes on the configuration port.
   localparam logic [INDEX_W-1:0] CSR_ATTACK_STEP   = 3'd0;
   localparam logic [INDEX_W-1:0] CSR_DECAY_STEP    = 3'd1;
   localparam logic [INDEX_W-1:0] CSR_SUSTAIN_LEVEL = 3'd2;
   localparam logic [INDEX_W-1:0] CSR_RELEASE_SCALE = 3'd3;
   localparam logic [INDEX_W-1:0] CSR_DECAY_ENABLE  = 3'd4;
   localparam logic [INDEX_W-1:0] CSR_RETRIGGER     = 3'd5;

   // Register values after reset.
   localparam logic [REG_W-1:0] RST_ATTACK_STEP   = 24'd1024;
   localparam logic [REG_W-1:0] RST_DECAY_STEP    = 24'd1024;
   localparam logic [REG_W-1:0] RST_SUSTAIN_LEVEL = 24'd4194304;
   localparam logic [REG_W-1:0] RST_RELEASE_SCALE = 24'd256;
   localparam logic             RST_DECAY_ENABLE  = 1'b1;
   localparam logic             RST_RETRIGGER     = 1'b0;

endpackage

### rtl/adsr_envelope_gain_top.sv
// Linear ADSR envelope used as the gain of an audio stream.
// Input channel (req_*): one beat is an audio sample, a note-on or a note-off.
// A sample with req_first_channel set advances the envelope one step through
// attack, decay, sustain and release before it is scaled; other samples are
// scaled by the current level. Note beats return audio_out of zero.
// Result channel (rsp_*): exactly one beat per input beat, in order, carrying
// the scaled sample, the envelope level after the item and the voice flag.
// Configuration (csr_*): a write lands on the edge where csr_we is high; write
// only while no item is in flight.
// From input acceptance to rsp_valid, the input register feeds the envelope
// update (add, compare and release multiply) into the scaling stage, and the
// sample multiply feeds the output register.
// Throughput is one beat per cycle while the receiver does not stall.
// When the receiver stalls, each stage holds and fills until req_ready drops;
// up to three beats sit in the pipe. Reset empties the pipe, sets the phase
// to idle with level and release step at zero, and loads register defaults.
module adsr_envelope_gain_top #(
   parameter int LEVEL_FRAC_BITS = 23,
   parameter int SAMPLE_BITS     = 24
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [adsr_pkg::ACT_W-1:0]          req_action,
   input  logic signed [SAMPLE_BITS-1:0]       req_audio_in,
   input  logic                                req_first_channel,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [SAMPLE_BITS-1:0]       rsp_audio_out,
   output logic [adsr_pkg::ENV_W-1:0]          rsp_envelope_level,
   output logic                                rsp_voice_active,
   input  logic                                csr_we,
   input  logic [adsr_pkg::INDEX_W-1:0]        csr_index,
   input  logic [adsr_pkg::REG_W-1:0]          csr_wdata
);

   localparam int REG_W   = adsr_pkg::REG_W;
   localparam int LEVEL_W = LEVEL_FRAC_BITS + 1;
   localparam int SUM_W   = ((LEVEL_W > REG_W) ? LEVEL_W : REG_W) + 1;
   localparam int REL_W   = LEVEL_W + REG_W;
   localparam int PROD_W  = SAMPLE_BITS + LEVEL_W + 1;
   localparam logic [SUM_W-1:0] FULL_SCALE = {{(SUM_W-1){1'b0}}, 1'b1} << LEVEL_FRAC_BITS;

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_ATTACK,
      PH_DECAY,
      PH_SUSTAIN,
      PH_RELEASE
   } phase_type;

   // Configuration registers.
   logic [REG_W-1:0] attack_step_ff;
   logic [REG_W-1:0] decay_step_ff;
   logic [REG_W-1:0] sustain_level_ff;
   logic [REG_W-1:0] release_scale_ff;
   logic             decay_enable_ff;
   logic             retrigger_ff;

   // Input stage.
   logic                         a_valid_ff;
   logic [adsr_pkg::ACT_W-1:0]   a_action_ff;
   logic signed [SAMPLE_BITS-1:0] a_audio_ff;
   logic                         a_first_ff;

   // Envelope state.
   phase_type          phase_ff, phase_in;
   logic [LEVEL_W-1:0] level_ff, level_in;
   logic [LEVEL_W-1:0] rstep_ff, rstep_in;

   // Scaling stage.
   logic                          b_valid_ff;
   logic                          b_sample_ff;
   logic signed [SAMPLE_BITS-1:0] b_audio_ff;
   logic [LEVEL_W-1:0]            b_level_ff;
   logic                          b_active_ff;

   // Output stage.
   logic                          rsp_valid_ff;
   logic signed [SAMPLE_BITS-1:0] rsp_audio_ff;
   logic [adsr_pkg::ENV_W-1:0]    rsp_level_ff;
   logic                          rsp_active_ff;

   logic c_ready;
   logic b_ready;
   logic a_ready;
   logic a_move;
   logic b_move;

   logic [SUM_W-1:0]        sustain_wide;
   logic [SUM_W-1:0]        sus_target;
   logic [REL_W-1:0]        rel_prod;
   logic signed [PROD_W-1:0] scale_prod;
   logic signed [PROD_W-1:0] scale_shift;

   // Stage handshake: each stage moves when the one after it can take a beat.
   assign c_ready   = !rsp_valid_ff || rsp_ready;
   assign b_ready   = !b_valid_ff || c_ready;
   assign a_ready   = !a_valid_ff || b_ready;
   assign a_move    = a_valid_ff && b_ready;
   assign b_move    = b_valid_ff && c_ready;
   assign req_ready = a_ready;

   // Configuration writes; unknown indexes are dropped.
   always_ff @(posedge clock) begin
      if (reset) begin
         attack_step_ff   <= adsr_pkg::RST_ATTACK_STEP;
         decay_step_ff    <= adsr_pkg::RST_DECAY_STEP;
         sustain_level_ff <= adsr_pkg::RST_SUSTAIN_LEVEL;
         release_scale_ff <= adsr_pkg::RST_RELEASE_SCALE;
         decay_enable_ff  <= adsr_pkg::RST_DECAY_ENABLE;
         retrigger_ff     <= adsr_pkg::RST_RETRIGGER;
      end else if (csr_we) begin
         unique case (csr_index)
            adsr_pkg::CSR_ATTACK_STEP:   attack_step_ff   <= csr_wdata;
            adsr_pkg::CSR_DECAY_STEP:    decay_step_ff    <= csr_wdata;
            adsr_pkg::CSR_SUSTAIN_LEVEL: sustain_level_ff <= csr_wdata;
            adsr_pkg::CSR_RELEASE_SCALE: release_scale_ff <= csr_wdata;
            adsr_pkg::CSR_DECAY_ENABLE:  decay_enable_ff  <= csr_wdata[0];
            adsr_pkg::CSR_RETRIGGER:     retrigger_ff     <= csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (a_ready) begin
         a_valid_ff <= req_valid;
      end
      if (a_ready && req_valid) begin
         a_action_ff <= req_action;
         a_audio_ff  <= req_audio_in;
         a_first_ff  <= req_first_channel;
      end
   end

   // Sustain target clamps at full scale.
   assign sustain_wide = SUM_W'(sustain_level_ff);
   assign sus_target   = (sustain_wide > FULL_SCALE) ? FULL_SCALE : sustain_wide;

   // Release step for a note-off, taken from the level before the note-off.
   assign rel_prod = REL_W'(level_ff) * REL_W'(release_scale_ff);

   // Next envelope state for the beat leaving the input register.
   always_comb begin
      logic [SUM_W-1:0] lvl;
      logic [SUM_W-1:0] step;
      logic [SUM_W-1:0] peak;
      logic [SUM_W-1:0] sum;
      logic [SUM_W-1:0] dstep;
      logic [SUM_W-1:0] rstep;

      lvl      = SUM_W'(level_ff);
      step     = (attack_step_ff == '0) ? SUM_W'(1) : SUM_W'(attack_step_ff);
      peak     = decay_enable_ff ? FULL_SCALE : sus_target;
      sum      = lvl + step;
      dstep    = SUM_W'(decay_step_ff);
      rstep    = SUM_W'(rstep_ff);
      phase_in = phase_ff;
      level_in = level_ff;
      rstep_in = rstep_ff;

      if (a_action_ff == adsr_pkg::ACT_SAMPLE) begin
         if (a_first_ff) begin
            unique case (phase_ff)
               PH_ATTACK: begin
                  if (sum >= peak) begin
                     level_in = LEVEL_W'(peak);
                     phase_in = decay_enable_ff ? PH_DECAY : PH_SUSTAIN;
                  end else begin
                     level_in = LEVEL_W'(sum);
                  end
               end
               PH_DECAY: begin
                  if (lvl <= sus_target + dstep) begin
                     level_in = LEVEL_W'(sus_target);
                     phase_in = PH_SUSTAIN;
                  end else begin
                     level_in = LEVEL_W'(lvl - dstep);
                  end
               end
               PH_RELEASE: begin
                  if (rstep >= lvl) begin
                     level_in = '0;
                     phase_in = PH_IDLE;
                  end else begin
                     level_in = LEVEL_W'(lvl - rstep);
                  end
               end
               PH_SUSTAIN: begin
                  level_in = LEVEL_W'(sus_target);
               end
               default: begin
                  level_in = '0;
                  phase_in = PH_IDLE;
               end
            endcase
         end
      end else if (a_action_ff == adsr_pkg::ACT_NOTE_ON) begin
         phase_in = PH_ATTACK;
         if (retrigger_ff) begin
            level_in = '0;
         end
      end else if (a_action_ff == adsr_pkg::ACT_NOTE_OFF) begin
         if (phase_ff != PH_IDLE) begin
            phase_in = PH_RELEASE;
            rstep_in = rel_prod[REL_W-1:REG_W];
         end
      end
   end

   // Envelope state and the scaling stage registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_IDLE;
         level_ff   <= '0;
         rstep_ff   <= '0;
         b_valid_ff <= 1'b0;
      end else begin
         if (a_move) begin
            phase_ff <= phase_in;
            level_ff <= level_in;
            rstep_ff <= rstep_in;
         end
         if (b_ready) begin
            b_valid_ff <= a_valid_ff;
         end
      end
      if (a_move) begin
         b_sample_ff <= (a_action_ff == adsr_pkg::ACT_SAMPLE);
         b_audio_ff  <= a_audio_ff;
         b_level_ff  <= level_in;
         b_active_ff <= (phase_in != PH_IDLE);
      end
   end

   // Sample times level, arithmetic shift rounds toward minus infinity.
   assign scale_prod  = PROD_W'(b_audio_ff) * $signed({1'b0, b_level_ff});
   assign scale_shift = scale_prod >>> LEVEL_FRAC_BITS;

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (c_ready) begin
         rsp_valid_ff <= b_valid_ff;
      end
      if (b_move) begin
         rsp_audio_ff  <= b_sample_ff ? scale_shift[SAMPLE_BITS-1:0] : '0;
         rsp_level_ff  <= adsr_pkg::ENV_W'(b_level_ff);
         rsp_active_ff <= b_active_ff;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_audio_out      = rsp_audio_ff;
   assign rsp_envelope_level = rsp_level_ff;
   assign rsp_voice_active   = rsp_active_ff;

   // An idle envelope always sits at zero.
   assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_IDLE) |-> (level_ff == '0))
      else $error("idle envelope with nonzero level");

   // The level never rises above full scale.
   assert property (@(posedge clock) disable iff (reset)
      SUM_W'(level_ff) <= FULL_SCALE)
      else $error("envelope level above full scale");

   // A note-on leaving the input register puts the envelope in attack.
   assert property (@(posedge clock) disable iff (reset)
      (a_move && a_action_ff == adsr_pkg::ACT_NOTE_ON) |=> (phase_ff == PH_ATTACK))
      else $error("note-on did not enter attack");

   // The voice flag of a beat in the scaling stage matches its level when idle.
   assert property (@(posedge clock) disable iff (reset)
      (b_valid_ff && !b_active_ff) |-> (b_level_ff == '0))
      else $error("inactive voice beat carries a level");

endmodule
